[hw/rtl/pta_pkg.sv]
package pta_pkg;

    localparam int MAX_AGE_VALUE     = 15;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int COUNT_BITS        = 32;

    localparam int NUM_BUCKETS = 16;

    // The age field is four bits wide, so the top age never exceeds 15.
    localparam int         AGE_TOP_INT = (MAX_AGE_VALUE > 15) ? 15 : MAX_AGE_VALUE;
    localparam logic [3:0] AGE_TOP     = 4'(AGE_TOP_INT);

    // The advanced counter is ten bits wide and stops at the table size.
    localparam int         ADV_CAP_INT = (ENTRIES_PER_TABLE > 1023) ? 1023 : ENTRIES_PER_TABLE;
    localparam logic [9:0] ADV_CAP     = 10'(ADV_CAP_INT);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef logic [3:0]            age_t;
    typedef logic signed [4:0]     max_t;
    typedef logic [COUNT_BITS-1:0] hist_cnt_t;
    typedef logic [9:0]            adv_cnt_t;

    localparam max_t NO_AGE = -5'sd1;

    // Classified entry handed from the front to the back.
    typedef struct packed {
        logic valid;
        logic adv;
        logic last;
        age_t age;
        age_t nage;
    } cmd_t;

    typedef struct packed {
        age_t        new_age;
        logic        advanced;
        logic [31:0] bucket_count;
        logic        region_done;
        max_t        region_old_max;
        max_t        region_new_max;
        logic        region_moves;
        adv_cnt_t    aged_total;
    } res_t;

endpackage

[hw/rtl/pta_front.sv]
module pta_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          entry_valid,
    input  logic          entry_accessed,
    input  logic [3:0]    entry_age,
    input  logic          last_entry,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output pta_pkg::cmd_t cmd
);
    import pta_pkg::*;

    cmd_t                 q_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 push_fire;
    logic                 pop_fire;
    cmd_t                 cls;

    // Work out the new age and the advanced flag as the beat comes in.
    always_comb
    begin
        cls.valid = entry_valid;
        cls.last  = last_entry;
        cls.age   = entry_age;
        if (!entry_valid)
        begin
            cls.nage = entry_age;
        end
        else if (entry_accessed)
        begin
            cls.nage = '0;
        end
        else if (entry_age < AGE_TOP)
        begin
            cls.nage = entry_age + 4'd1;
        end
        else
        begin
            cls.nage = AGE_TOP;
        end
        cls.adv = entry_valid && (entry_accessed || (cls.nage > entry_age));
    end

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push_fire = push && !full;
    assign pop_fire  = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && !pop_fire |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue lost a beat");

    a_count_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && !push_fire |=> count_reg == $past(count_reg) - 1'b1)
        else $error("command queue repeated a beat");

endmodule

[hw/rtl/pta_back.sv]
module pta_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  pta_pkg::cmd_t cmd,
    output logic          empty,
    input  logic          pop,
    output pta_pkg::res_t res
);
    import pta_pkg::*;

    logic [NUM_BUCKETS-1:0][COUNT_BITS-1:0] hist_reg;
    logic [NUM_BUCKETS-1:0][COUNT_BITS-1:0] hist_next;
    max_t                 old_max_reg;
    max_t                 old_max_next;
    max_t                 new_max_reg;
    max_t                 new_max_next;
    adv_cnt_t             adv_cnt_reg;
    adv_cnt_t             adv_cnt_next;
    max_t                 old_max_upd;
    max_t                 new_max_upd;
    adv_cnt_t             adv_cnt_upd;
    logic                 move;
    logic [63:0]          bucket_wide;
    logic                 fire;
    res_t                 res_in;

    res_t                 q_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] count_next;
    logic                 res_full;
    logic                 pop_fire;

    assign res_full  = (count_reg == RES_CNT_W'(RES_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_fire  = pop && !empty;
    // A slot frees up in the same cycle that the oldest result is taken.
    assign cmd_ready = !res_full || pop_fire;
    assign fire      = cmd_valid && cmd_ready;
    assign move      = cmd.valid && (cmd.nage != cmd.age);

    // Each bucket updates on its own; old and new bucket differ whenever a move happens.
    always_comb
    begin
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            hist_next[i] = hist_reg[i];
            if (move && (cmd.age == 4'(i)) && (hist_reg[i] != '0))
            begin
                hist_next[i] = hist_reg[i] - 1'b1;
            end
            else if (move && (cmd.nage == 4'(i)) && (hist_reg[i] != COUNT_MAX))
            begin
                hist_next[i] = hist_reg[i] + 1'b1;
            end
        end
    end

    always_comb
    begin
        old_max_upd = old_max_reg;
        new_max_upd = new_max_reg;
        adv_cnt_upd = adv_cnt_reg;
        if (cmd.valid && (max_t'({1'b0, cmd.age}) > old_max_reg))
        begin
            old_max_upd = max_t'({1'b0, cmd.age});
        end
        if (cmd.valid && (max_t'({1'b0, cmd.nage}) > new_max_reg))
        begin
            new_max_upd = max_t'({1'b0, cmd.nage});
        end
        if (cmd.adv && (adv_cnt_reg < ADV_CAP))
        begin
            adv_cnt_upd = adv_cnt_reg + 1'b1;
        end
    end

    assign bucket_wide = 64'(hist_next[cmd.nage]);

    always_comb
    begin
        res_in.new_age      = cmd.nage;
        res_in.advanced     = cmd.adv;
        res_in.bucket_count = bucket_wide[31:0];
        res_in.region_done  = cmd.last;
        res_in.aged_total   = adv_cnt_upd;
        if (cmd.last)
        begin
            res_in.region_old_max = old_max_upd;
            res_in.region_new_max = new_max_upd;
            res_in.region_moves   = (old_max_upd != new_max_upd);
        end
        else
        begin
            res_in.region_old_max = '0;
            res_in.region_new_max = '0;
            res_in.region_moves   = 1'b0;
        end
    end

    // The last entry closes the table and starts a fresh region summary.
    always_comb
    begin
        if (cmd.last)
        begin
            old_max_next = NO_AGE;
            new_max_next = NO_AGE;
            adv_cnt_next = '0;
        end
        else
        begin
            old_max_next = old_max_upd;
            new_max_next = new_max_upd;
            adv_cnt_next = adv_cnt_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg    <= '0;
            old_max_reg <= NO_AGE;
            new_max_reg <= NO_AGE;
            adv_cnt_reg <= '0;
        end
        else if (fire)
        begin
            hist_reg    <= hist_next;
            old_max_reg <= old_max_next;
            new_max_reg <= new_max_next;
            adv_cnt_reg <= adv_cnt_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (fire)
        begin
            wr_ptr_next = (wr_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({fire, pop_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

    assign res = q_reg[rd_ptr_reg];

    a_region_reset: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.last |=> old_max_reg == NO_AGE && new_max_reg == NO_AGE
            && adv_cnt_reg == '0)
        else $error("region state not cleared after last entry");

    a_invalid_hist: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !cmd.valid |=> $stable(hist_reg))
        else $error("invalid entry changed the histogram");

    a_adv_cap: assert property (@(posedge clk) disable iff (!rst_n)
        adv_cnt_reg <= ADV_CAP)
        else $error("advanced count passed its cap");

    a_max_order: assert property (@(posedge clk) disable iff (!rst_n)
        (old_max_reg == NO_AGE) == (new_max_reg == NO_AGE))
        else $error("running maxima disagree on an empty region");

endmodule

[hw/rtl/page_table_leaf_ager.sv]
// Flow: an entry waits in the command queue, then the back end updates the histogram
// and writes the result into the result queue, from which it can be popped.
// Throughput: one entry per cycle while the result side keeps popping, set by the histogram
// update in the back end; two-deep queues on each side absorb stalls.
// Reset: queues empty, histogram all zero, running maxima at -1, advanced count 0.
module page_table_leaf_ager (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              entry_valid,
    input  logic              entry_accessed,
    input  logic [3:0]        entry_age,
    input  logic              last_entry,
    output logic              empty,
    input  logic              pop,
    output logic [3:0]        new_age,
    output logic              advanced,
    output logic [31:0]       bucket_count,
    output logic              region_done,
    output logic signed [4:0] region_old_max,
    output logic signed [4:0] region_new_max,
    output logic              region_moves,
    output logic [9:0]        aged_total
);
    import pta_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;
    res_t res;

    pta_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .entry_valid    (entry_valid),
        .entry_accessed (entry_accessed),
        .entry_age      (entry_age),
        .last_entry     (last_entry),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    pta_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign new_age        = res.new_age;
    assign advanced       = res.advanced;
    assign bucket_count   = res.bucket_count;
    assign region_done    = res.region_done;
    assign region_old_max = res.region_old_max;
    assign region_new_max = res.region_new_max;
    assign region_moves   = res.region_moves;
    assign aged_total     = res.aged_total;

endmodule

[dv/page_table_leaf_ager_checker.sv]
`timescale 1ns / 100ps

module page_table_leaf_ager_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic              entry_valid,
    input  logic              entry_accessed,
    input  logic [3:0]        entry_age,
    input  logic              last_entry,
    input  logic              empty,
    input  logic              pop,
    input  logic [3:0]        new_age,
    input  logic              advanced,
    input  logic [31:0]       bucket_count,
    input  logic              region_done,
    input  logic signed [4:0] region_old_max,
    input  logic signed [4:0] region_new_max,
    input  logic              region_moves,
    input  logic [9:0]        aged_total,
    output int                pending,
    output int                mismatches
);
    import pta_pkg::*;

    hist_cnt_t age_hist [NUM_BUCKETS];
    int        table_old_max;
    int        table_new_max;
    adv_cnt_t  table_adv_count;
    res_t      aged_entries_due [$];

    // Ages one entry against the shadow histogram and table trackers.
    task automatic age_one_entry(input logic v, input logic a, input age_t age,
                                 input logic last, output res_t r);
        age_t nage;
        logic adv;
        nage = age;
        adv  = 1'b0;
        if (v)
        begin
            if (a)
            begin
                nage = '0;
                adv  = 1'b1;
            end
            else
            begin
                nage = (age < AGE_TOP) ? age + 4'd1 : AGE_TOP;
                adv  = (nage > age);
            end
            if (nage != age)
            begin
                if (age_hist[age] != '0)
                    age_hist[age] = age_hist[age] - 1'b1;
                if (age_hist[nage] != COUNT_MAX)
                    age_hist[nage] = age_hist[nage] + 1'b1;
            end
            if (int'(age) > table_old_max)
                table_old_max = int'(age);
            if (int'(nage) > table_new_max)
                table_new_max = int'(nage);
            if (adv && table_adv_count < ADV_CAP)
                table_adv_count = table_adv_count + 1'b1;
        end
        r.new_age        = nage;
        r.advanced       = adv;
        r.bucket_count   = 32'(age_hist[nage]);
        r.region_done    = last;
        r.region_old_max = last ? max_t'(table_old_max) : '0;
        r.region_new_max = last ? max_t'(table_new_max) : '0;
        r.region_moves   = last && (table_old_max != table_new_max);
        r.aged_total     = table_adv_count;
        if (last)
        begin
            table_old_max   = -1;
            table_new_max   = -1;
            table_adv_count = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
                age_hist[i] = '0;
            table_old_max   = -1;
            table_new_max   = -1;
            table_adv_count = '0;
            aged_entries_due.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                age_one_entry(entry_valid, entry_accessed, entry_age, last_entry, want);
                aged_entries_due.push_back(want);
            end
            if (pop && !empty)
            begin
                got.new_age        = new_age;
                got.advanced       = advanced;
                got.bucket_count   = bucket_count;
                got.region_done    = region_done;
                got.region_old_max = region_old_max;
                got.region_new_max = region_new_max;
                got.region_moves   = region_moves;
                got.aged_total     = aged_total;
                if (aged_entries_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result beat with nothing expected: age %0d total %0d",
                                 $realtime, got.new_age, got.aged_total);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = aged_entries_due.pop_front();
                    if (got.new_age !== want.new_age || got.advanced !== want.advanced
                        || got.bucket_count !== want.bucket_count
                        || got.region_done !== want.region_done
                        || got.region_old_max !== want.region_old_max
                        || got.region_new_max !== want.region_new_max
                        || got.region_moves !== want.region_moves
                        || got.aged_total !== want.aged_total)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: result beat mismatch", $realtime);
                            $display("  expected age %0d adv %0b bucket %0d done %0b",
                                     want.new_age, want.advanced, want.bucket_count,
                                     want.region_done);
                            $display("           old %0d new %0d moves %0b total %0d",
                                     want.region_old_max, want.region_new_max,
                                     want.region_moves, want.aged_total);
                            $display("  actual   age %0d adv %0b bucket %0d done %0b",
                                     got.new_age, got.advanced, got.bucket_count,
                                     got.region_done);
                            $display("           old %0d new %0d moves %0b total %0d",
                                     got.region_old_max, got.region_new_max,
                                     got.region_moves, got.aged_total);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= aged_entries_due.size();
        end
    end

endmodule

[dv/tb_page_table_leaf_ager.sv]
`timescale 1ns / 100ps

module tb_page_table_leaf_ager;
    import pta_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              entry_valid;
    logic              entry_accessed;
    logic [3:0]        entry_age;
    logic              last_entry;
    logic              empty;
    logic              pop;
    logic [3:0]        new_age;
    logic              advanced;
    logic [31:0]       bucket_count;
    logic              region_done;
    logic signed [4:0] region_old_max;
    logic signed [4:0] region_new_max;
    logic              region_moves;
    logic [9:0]        aged_total;
    int                pending;
    int                mismatches;

    logic idle_on;
    int   entries_sent;

    page_table_leaf_ager u_dut (.*);

    page_table_leaf_ager_checker u_chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("page_table_leaf_ager test failed");
        $finish;
    end

    task automatic send_entry(input logic v, input logic a, input logic [3:0] age,
                              input logic last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push           <= 1'b1;
        entry_valid    <= v;
        entry_accessed <= a;
        entry_age      <= age;
        last_entry     <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        entries_sent++;
    endtask

    // Flavors: 0 is a busy table, 1 is mostly invalid entries, 2 is a cold
    // table sitting near the top age.
    task automatic send_table(input int len, input int flavor);
        logic v;
        logic a;
        logic [3:0] age;
        for (int i = 0; i < len; i++)
        begin
            v   = (flavor == 1) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 9) != 0);
            a   = (flavor == 2) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 2) == 0);
            age = (flavor == 2) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 15));
            send_entry(v, a, age, i == len - 1);
        end
    endtask

    // Result side: random pop bursts, plus one long hold so the block backs up.
    initial
    begin
        int   cyc;
        int   k;
        logic held;
        pop  = 1'b0;
        cyc  = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && cyc >= 300)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (64) @(posedge clk);
                cyc += 64;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                k = $urandom_range(1, 3);
                pop <= 1'b0;
                repeat (k) @(posedge clk);
                cyc += k;
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
                cyc++;
            end
        end
    end

    initial
    begin
        int len;
        rst_n          = 1'b0;
        push           = 1'b0;
        entry_valid    = 1'b0;
        entry_accessed = 1'b0;
        entry_age      = '0;
        last_entry     = 1'b0;
        idle_on        = 1'b1;
        entries_sent   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Invalid entries at both age extremes, then saturation at the top age.
        send_entry(1'b0, 1'b0, 4'd0, 1'b0);
        send_entry(1'b0, 1'b1, 4'd15, 1'b0);
        send_entry(1'b1, 1'b0, 4'd15, 1'b0);
        send_entry(1'b1, 1'b1, 4'd15, 1'b0);
        send_entry(1'b1, 1'b0, 4'd0, 1'b0);
        send_entry(1'b1, 1'b0, 4'd14, 1'b1);
        // A table with no valid entry reports minus one for both maxima.
        send_entry(1'b0, 1'b0, 4'd7, 1'b0);
        send_entry(1'b0, 1'b1, 4'd3, 1'b1);
        // Single-entry tables: one that moves and one that stays put.
        send_entry(1'b1, 1'b1, 4'd9, 1'b1);
        send_entry(1'b1, 1'b0, 4'd15, 1'b1);
        // Decrements of empty buckets stop at zero.
        send_entry(1'b1, 1'b0, 4'd5, 1'b0);
        send_entry(1'b1, 1'b0, 4'd10, 1'b0);
        send_entry(1'b0, 1'b1, 4'd12, 1'b0);
        send_entry(1'b1, 1'b1, 4'd0, 1'b0);
        send_entry(1'b1, 1'b0, 4'd1, 1'b0);
        send_entry(1'b1, 1'b1, 4'd6, 1'b1);
        send_entry(1'b1, 1'b0, 4'd3, 1'b0);
        send_entry(1'b1, 1'b0, 4'd4, 1'b0);
        send_entry(1'b1, 1'b0, 4'd8, 1'b1);

        // One table longer than the table size, with every entry advancing, so the
        // advanced count runs into its cap.
        for (int i = 0; i < 530; i++)
            send_entry(1'b1, $urandom_range(0, 7) == 0, 4'($urandom_range(0, 14)), i == 529);

        while (entries_sent < 1950)
        begin
            if (entries_sent >= 1750)
                idle_on = 1'b0;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            send_table(len, ($urandom_range(0, 5) == 0) ? 1 : ($urandom_range(0, 3) == 0) ? 2 : 0);
        end
        push <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("page_table_leaf_ager test passed");
        else
            $display("page_table_leaf_ager test failed");
        $finish;
    end

endmodule
